[hdl/ipt_pkg.sv]
// Package for the isometric pixel-to-tile picker.
// Payload structs, configuration struct, register indexes and divider constants.
// No dependencies.
`default_nettype none

package ipt_pkg;

    localparam int VIEW_COLUMNS_DEF = 256;
    localparam int VIEW_ROWS_DEF    = 512;
    localparam int VIEWPORT_TOP_DEF = 24;

    localparam int TILE_W      = 60;
    localparam int HALF_TILE_W = 30;
    localparam int HALF_TILE_H = 15;

    // floor(n/100) = (n*RECIP_100) >> SHIFT_100 for n < 2^21
    localparam logic [21:0] RECIP_100 = 22'd2684355;
    localparam int          SHIFT_100 = 28;
    // floor(n/30) = (n*RECIP_30) >> 20, floor(n/15) = (n*RECIP_15) >> 19, n < 2^15
    localparam logic [15:0] RECIP_30  = 16'd34953;
    localparam int          SHIFT_30  = 20;
    localparam logic [15:0] RECIP_15  = 16'd34953;
    localparam int          SHIFT_15  = 19;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        REG_VIEWPORT_LEFT   = 3'd0,
        REG_VIEWPORT_WIDTH  = 3'd1,
        REG_VIEWPORT_HEIGHT = 3'd2,
        REG_ZOOM_PERCENT    = 3'd3,
        REG_CAM_SUBTILE_X   = 3'd4,
        REG_CAM_SUBTILE_Y   = 3'd5,
        REG_CAM_TILE_X      = 3'd6,
        REG_CAM_TILE_Y      = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [11:0] screen_x;
        logic [11:0] screen_y;
    } t_pick_in;

    typedef struct packed {
        logic               hit;
        logic signed [11:0] view_col;
        logic signed [11:0] view_row;
    } t_pick_out;

    typedef struct packed {
        logic [11:0]        viewport_left;
        logic [12:0]        viewport_width;
        logic [12:0]        viewport_height;
        logic [8:0]         zoom_percent;
        logic [5:0]         camera_subtile_x;
        logic [4:0]         camera_subtile_y;
        logic signed [10:0] camera_tile_x;
        logic signed [10:0] camera_tile_y;
    } t_cfg;

endpackage

`default_nettype wire

[hdl/ipt_cfg_regs.sv]
// APB-style configuration register file for the tile picker.
// Depends on ipt_pkg (t_cfg, t_reg_idx, bus widths).
`default_nettype none

module ipt_cfg_regs (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [ipt_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [ipt_pkg::DATA_W-1:0]  pwdata,
    output logic      [ipt_pkg::DATA_W-1:0]  prdata,
    output logic                             pready,
    output ipt_pkg::t_cfg                    o_cfg
);

    ipt_pkg::t_cfg    r_cfg;
    ipt_pkg::t_reg_idx w_idx;
    logic             w_wr;

    assign w_idx  = ipt_pkg::t_reg_idx'(paddr[ipt_pkg::ADDR_W-1:2]);
    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.viewport_left    <= 12'd0;
            r_cfg.viewport_width   <= 13'd1024;
            r_cfg.viewport_height  <= 13'd768;
            r_cfg.zoom_percent     <= 9'd100;
            r_cfg.camera_subtile_x <= 6'd0;
            r_cfg.camera_subtile_y <= 5'd0;
            r_cfg.camera_tile_x    <= 11'sd0;
            r_cfg.camera_tile_y    <= 11'sd0;
        end else if (w_wr) begin
            case (w_idx)
                ipt_pkg::REG_VIEWPORT_LEFT:   r_cfg.viewport_left    <= pwdata[11:0];
                ipt_pkg::REG_VIEWPORT_WIDTH:  r_cfg.viewport_width   <= pwdata[12:0];
                ipt_pkg::REG_VIEWPORT_HEIGHT: r_cfg.viewport_height  <= pwdata[12:0];
                ipt_pkg::REG_ZOOM_PERCENT:    r_cfg.zoom_percent     <= pwdata[8:0];
                ipt_pkg::REG_CAM_SUBTILE_X:   r_cfg.camera_subtile_x <= pwdata[5:0];
                ipt_pkg::REG_CAM_SUBTILE_Y:   r_cfg.camera_subtile_y <= pwdata[4:0];
                ipt_pkg::REG_CAM_TILE_X:      r_cfg.camera_tile_x    <= $signed(pwdata[10:0]);
                ipt_pkg::REG_CAM_TILE_Y:      r_cfg.camera_tile_y    <= $signed(pwdata[10:0]);
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            ipt_pkg::REG_VIEWPORT_LEFT:   prdata = 32'(r_cfg.viewport_left);
            ipt_pkg::REG_VIEWPORT_WIDTH:  prdata = 32'(r_cfg.viewport_width);
            ipt_pkg::REG_VIEWPORT_HEIGHT: prdata = 32'(r_cfg.viewport_height);
            ipt_pkg::REG_ZOOM_PERCENT:    prdata = 32'(r_cfg.zoom_percent);
            ipt_pkg::REG_CAM_SUBTILE_X:   prdata = 32'(r_cfg.camera_subtile_x);
            ipt_pkg::REG_CAM_SUBTILE_Y:   prdata = 32'(r_cfg.camera_subtile_y);
            ipt_pkg::REG_CAM_TILE_X:      prdata = {21'd0, r_cfg.camera_tile_x};
            ipt_pkg::REG_CAM_TILE_Y:      prdata = {21'd0, r_cfg.camera_tile_y};
            default:                      prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

[hdl/ipt_pick_pipe.sv]
// Six-stage pick pipeline: viewport test, zoom scaling, tile quotients, diamond choice.
// Depends on ipt_pkg (payload structs, t_cfg, reciprocal constants).
`default_nettype none

module ipt_pick_pipe #(
    parameter int VIEW_COLUMNS = ipt_pkg::VIEW_COLUMNS_DEF,
    parameter int VIEW_ROWS    = ipt_pkg::VIEW_ROWS_DEF,
    parameter int VIEWPORT_TOP = ipt_pkg::VIEWPORT_TOP_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  ipt_pkg::t_pick_in  i_pixel,
    input  ipt_pkg::t_cfg      i_cfg,
    output logic               o_done,
    output ipt_pkg::t_pick_out o_result
);

    // stage 1: viewport test and zoom products
    logic        r1_v, r1_in;
    logic [20:0] r1_px, r1_py;
    logic        n1_in;
    logic [13:0] w_right, w_bottom, w_top;

    assign w_top    = 14'(VIEWPORT_TOP);
    assign w_right  = 14'(i_cfg.viewport_left) + 14'(i_cfg.viewport_width);
    assign w_bottom = w_top + 14'(i_cfg.viewport_height);
    assign n1_in = !((i_pixel.screen_x < i_cfg.viewport_left) ||
                     (14'(i_pixel.screen_x) >= w_right) ||
                     (14'(i_pixel.screen_y) < w_top) ||
                     (14'(i_pixel.screen_y) >= w_bottom));

    // stage 2: divide by 100 through reciprocal
    logic        r2_v, r2_in;
    logic [42:0] r2_qx, r2_qy;

    // stage 3: offsets, sign and magnitude
    logic        r3_v, r3_in, r3_negx, r3_negy;
    logic [14:0] r3_ax, r3_ay;
    logic [15:0] n3_dx, n3_dy;

    assign n3_dx = 16'(r2_qx[42:ipt_pkg::SHIFT_100]) + 16'(i_cfg.camera_subtile_x)
                 - 16'(i_cfg.viewport_left);
    assign n3_dy = 16'(r2_qy[42:ipt_pkg::SHIFT_100]) + 16'(i_cfg.camera_subtile_y)
                 - 16'(VIEWPORT_TOP);

    // stage 4: divide by 30 and 15 through reciprocal
    logic        r4_v, r4_in, r4_negx, r4_negy;
    logic [14:0] r4_ax, r4_ay;
    logic [30:0] r4_mx, r4_my;

    // stage 5: signed quotients and remainders
    logic               r5_v, r5_in, r5_xodd, r5_yodd;
    logic signed [13:0] r5_col, r5_row;
    logic signed [4:0]  r5_xmod, r5_ymod;
    logic [9:0]         n5_uqx;
    logic [10:0]        n5_uqy;
    logic [4:0]         n5_rx;
    logic [3:0]         n5_ry;
    logic [13:0]        n5_hx, n5_uy;
    logic [4:0]         n5_hrx, n5_ury;

    assign n5_uqx = r4_mx[29:ipt_pkg::SHIFT_30];
    assign n5_uqy = r4_my[29:ipt_pkg::SHIFT_15];
    assign n5_rx  = 5'(r4_ax - 15'(n5_uqx) * 15'(ipt_pkg::HALF_TILE_W));
    assign n5_ry  = 4'(r4_ay - 15'(n5_uqy) * 15'(ipt_pkg::HALF_TILE_H));
    assign n5_hx  = 14'(n5_uqx[9:1]);
    assign n5_uy  = 14'(n5_uqy);
    assign n5_hrx = 5'(n5_rx[4:1]);
    assign n5_ury = 5'(n5_ry);

    // stage 6: diamond choice, camera tile, bounds
    logic               r_done;
    ipt_pkg::t_pick_out r_result;
    logic               n6_odd, n6_row_inc, n6_col_inc, n6_hit;
    logic signed [5:0]  n6_sum;
    logic signed [13:0] n6_col, n6_row;

    always_comb begin
        n6_odd     = r5_xodd ^ r5_yodd;
        n6_sum     = 6'(r5_xmod) + 6'(r5_ymod);
        n6_row_inc = 1'b0;
        n6_col_inc = 1'b0;
        if (n6_odd) begin
            if (n6_sum >= 6'(ipt_pkg::HALF_TILE_H - 1)) begin
                n6_row_inc = 1'b1;
                n6_col_inc = r5_xodd & !r5_yodd;
            end
        end else begin
            if (r5_ymod > r5_xmod) begin
                n6_row_inc = 1'b1;
            end else begin
                n6_col_inc = r5_xodd & r5_yodd;
            end
        end
        n6_col = 14'(i_cfg.camera_tile_x) + r5_col + $signed({13'd0, n6_col_inc});
        n6_row = 14'(i_cfg.camera_tile_y) + r5_row + $signed({13'd0, n6_row_inc});
        n6_hit = (n6_col >= 14'sd0) && (n6_col < $signed(14'(VIEW_COLUMNS))) &&
                 (n6_row >= 14'sd0) && (n6_row < $signed(14'(VIEW_ROWS)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v   <= 1'b0;
            r2_v   <= 1'b0;
            r3_v   <= 1'b0;
            r4_v   <= 1'b0;
            r5_v   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r1_v   <= i_valid;
            r2_v   <= r1_v;
            r3_v   <= r2_v;
            r4_v   <= r3_v;
            r5_v   <= r4_v;
            r_done <= r5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_in <= n1_in;
        r1_px <= 21'(i_pixel.screen_x) * 21'(i_cfg.zoom_percent);
        r1_py <= 21'(i_pixel.screen_y) * 21'(i_cfg.zoom_percent);

        r2_in <= r1_in;
        r2_qx <= 43'(r1_px) * 43'(ipt_pkg::RECIP_100);
        r2_qy <= 43'(r1_py) * 43'(ipt_pkg::RECIP_100);

        r3_in   <= r2_in;
        r3_negx <= n3_dx[15];
        r3_negy <= n3_dy[15];
        r3_ax   <= n3_dx[15] ? 15'(-n3_dx) : n3_dx[14:0];
        r3_ay   <= n3_dy[15] ? 15'(-n3_dy) : n3_dy[14:0];

        r4_in   <= r3_in;
        r4_negx <= r3_negx;
        r4_negy <= r3_negy;
        r4_ax   <= r3_ax;
        r4_ay   <= r3_ay;
        r4_mx   <= 31'(r3_ax) * 31'(ipt_pkg::RECIP_30);
        r4_my   <= 31'(r3_ay) * 31'(ipt_pkg::RECIP_15);

        r5_in   <= r4_in;
        r5_xodd <= n5_uqx[0];
        r5_yodd <= n5_uqy[0];
        r5_col  <= r4_negx ? $signed(-n5_hx)  : $signed(n5_hx);
        r5_row  <= r4_negy ? $signed(-n5_uy)  : $signed(n5_uy);
        r5_xmod <= r4_negx ? $signed(-n5_hrx) : $signed(n5_hrx);
        r5_ymod <= r4_negy ? $signed(-n5_ury) : $signed(n5_ury);

        if (r5_in) begin
            r_result.hit      <= n6_hit;
            r_result.view_col <= n6_col[11:0];
            r_result.view_row <= n6_row[11:0];
        end else begin
            r_result <= '0;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

`default_nettype wire

[hdl/isometric_pixel_to_tile_pick.sv]
// Top level of the isometric pixel-to-tile picker.
// Depends on ipt_pkg, ipt_cfg_regs and ipt_pick_pipe.
`default_nettype none

// Takes one pixel per clock: busy is never raised, so a start is accepted in every
// cycle. Each pick returns through the pipeline registers, strobed by o_done for
// one cycle, in start order; a register follows each of the zoom multiply, the
// divide-by-100 reciprocal multiply, the offset and sign step, the divide-by-30/15
// reciprocal multiply, the quotient step and the diamond choice. Results cannot be
// held off and must be captured when o_done is high. The user must write
// configuration over the APB port only while no pick is in flight; the block does not enforce it.
module isometric_pixel_to_tile_pick #(
    parameter int VIEW_COLUMNS = ipt_pkg::VIEW_COLUMNS_DEF,
    parameter int VIEW_ROWS    = ipt_pkg::VIEW_ROWS_DEF,
    parameter int VIEWPORT_TOP = ipt_pkg::VIEWPORT_TOP_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [ipt_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [ipt_pkg::DATA_W-1:0]  pwdata,
    output logic      [ipt_pkg::DATA_W-1:0]  prdata,
    output logic                             pready,
    input  wire logic                        start,
    output logic                             busy,
    input  ipt_pkg::t_pick_in                i_pixel,
    output logic                             o_done,
    output ipt_pkg::t_pick_out               o_result
);

    ipt_pkg::t_cfg w_cfg;

    assign busy = 1'b0;

    ipt_cfg_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    ipt_pick_pipe #(
        .VIEW_COLUMNS (VIEW_COLUMNS),
        .VIEW_ROWS    (VIEW_ROWS),
        .VIEWPORT_TOP (VIEWPORT_TOP)
    ) u_pipe (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (start & !busy),
        .i_pixel  (i_pixel),
        .i_cfg    (w_cfg),
        .o_done   (o_done),
        .o_result (o_result)
    );

endmodule

`default_nettype wire

[hdl/ipt_checker.sv]
// Port-level assertions for the tile picker, bound to the top level.
// Depends on ipt_pkg and isometric_pixel_to_tile_pick.
`default_nettype none

module ipt_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        pready,
    input wire logic                        start,
    input wire logic                        busy,
    input wire logic                        o_done,
    input ipt_pkg::t_pick_out               o_result
);

    a_done_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, 6))
        else $error("result strobe without a transaction six cycles earlier");

    a_hit_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.hit) |-> (!o_result.view_col[11] && !o_result.view_row[11]))
        else $error("hit reported on a negative tile");

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy && pready)
        else $error("busy raised or pready dropped");

    a_miss_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_done |=> !o_done || $past(start && !busy, 6))
        else $error("result strobe out of pipeline order");

endmodule

bind isometric_pixel_to_tile_pick ipt_checker u_ipt_checker (.*);

`default_nettype wire

[dv/tb_top.sv]
// Self-checking testbench for isometric_pixel_to_tile_pick: picks go in on a start handshake,
// registers are set over the APB port, results are checked against an in-bench tile predictor.
// Depends on ipt_pkg and the RTL top level.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COLS          = ipt_pkg::VIEW_COLUMNS_DEF;
    localparam int ROWS          = ipt_pkg::VIEW_ROWS_DEF;
    localparam int TOP           = ipt_pkg::VIEWPORT_TOP_DEF;
    localparam int SETTLE_CYCLES = 10;
    localparam int PHASE_PICKS   = 50;

    typedef enum logic [1:0] {CMD_PICK, CMD_WRITE, CMD_SETTLE} t_cmd_kind;
    typedef enum logic [1:0] {APB_IDLE, APB_SETUP, APB_ACCESS} t_apb_state;

    typedef struct {
        t_cmd_kind          kind;
        ipt_pkg::t_pick_in  pixel;
        int                 gap_pct;
        ipt_pkg::t_reg_idx  reg_idx;
        logic [31:0]        wdata;
    } t_drive_cmd;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [ipt_pkg::ADDR_W-1:0] paddr = '0;
    logic [ipt_pkg::DATA_W-1:0] pwdata = '0;
    logic [ipt_pkg::DATA_W-1:0] prdata;
    logic                       pready;
    logic                       start = 1'b0;
    logic                       busy;
    ipt_pkg::t_pick_in          i_pixel = '0;
    logic                       o_done;
    ipt_pkg::t_pick_out         o_result;

    t_drive_cmd          drive_q[$];
    ipt_pkg::t_pick_out  tile_q[$];
    ipt_pkg::t_cfg       cfg_shadow;
    t_apb_state          apb_st = APB_IDLE;
    logic                pick_accepted = 1'b0;
    int                  settle_cnt = 0;
    int                  n_checked = 0;
    int                  n_hits = 0;
    int                  n_fail = 0;
    int                  n_settings = 0;

    isometric_pixel_to_tile_pick #(
        .VIEW_COLUMNS (COLS),
        .VIEW_ROWS    (ROWS),
        .VIEWPORT_TOP (TOP)
    ) DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .start    (start),
        .busy     (busy),
        .i_pixel  (i_pixel),
        .o_done   (o_done),
        .o_result (o_result)
    );

    always #4 i_clk = ~i_clk;

    function automatic ipt_pkg::t_pick_out pick_tile(ipt_pkg::t_pick_in p, ipt_pkg::t_cfg c);
        int                 sx, sy, left, px, py, dx, dy, qx, qy;
        int                 x_mod, y_mod, col_off, row_off, col, row;
        logic               odd, x_odd, y_odd;
        ipt_pkg::t_pick_out r;
        sx   = int'(p.screen_x);
        sy   = int'(p.screen_y);
        left = int'(c.viewport_left);
        r    = '0;
        if (sx < left || sx >= left + int'(c.viewport_width) ||
            sy < TOP || sy >= TOP + int'(c.viewport_height)) begin
            return r;
        end
        px      = (sx * int'(c.zoom_percent)) / 100 + int'(c.camera_subtile_x);
        py      = (sy * int'(c.zoom_percent)) / 100 + int'(c.camera_subtile_y);
        dx      = px - left;
        dy      = py - TOP;
        qx      = dx / ipt_pkg::HALF_TILE_W;
        qy      = dy / ipt_pkg::HALF_TILE_H;
        odd     = ((qx + qy) & 1) != 0;
        x_odd   = (qx & 1) != 0;
        y_odd   = (qy & 1) != 0;
        x_mod   = (dx % ipt_pkg::HALF_TILE_W) / 2;
        y_mod   = dy % ipt_pkg::HALF_TILE_H;
        col_off = dx / ipt_pkg::TILE_W;
        row_off = qy;
        if (odd) begin
            if (x_mod + y_mod >= ipt_pkg::HALF_TILE_H - 1) begin
                row_off++;
                if (x_odd && !y_odd) col_off++;
            end
        end else if (y_mod > x_mod) begin
            row_off++;
        end else if (x_odd && y_odd) begin
            col_off++;
        end
        col        = int'($signed(c.camera_tile_x)) + col_off;
        row        = int'($signed(c.camera_tile_y)) + row_off;
        r.hit      = col >= 0 && col < COLS && row >= 0 && row < ROWS;
        r.view_col = 12'(col);
        r.view_row = 12'(row);
        return r;
    endfunction

    function automatic void cfg_apply(ipt_pkg::t_reg_idx idx, logic [31:0] d);
        case (idx)
            ipt_pkg::REG_VIEWPORT_LEFT:   cfg_shadow.viewport_left    = d[11:0];
            ipt_pkg::REG_VIEWPORT_WIDTH:  cfg_shadow.viewport_width   = d[12:0];
            ipt_pkg::REG_VIEWPORT_HEIGHT: cfg_shadow.viewport_height  = d[12:0];
            ipt_pkg::REG_ZOOM_PERCENT:    cfg_shadow.zoom_percent     = d[8:0];
            ipt_pkg::REG_CAM_SUBTILE_X:   cfg_shadow.camera_subtile_x = d[5:0];
            ipt_pkg::REG_CAM_SUBTILE_Y:   cfg_shadow.camera_subtile_y = d[4:0];
            ipt_pkg::REG_CAM_TILE_X:      cfg_shadow.camera_tile_x    = d[10:0];
            ipt_pkg::REG_CAM_TILE_Y:      cfg_shadow.camera_tile_y    = d[10:0];
            default: ;
        endcase
    endfunction

    // driver: inputs change on the falling edge
    always @(negedge i_clk) begin : drv
        logic                       nx_start, nx_psel, nx_penable, nx_pwrite;
        logic [ipt_pkg::ADDR_W-1:0] nx_paddr;
        logic [ipt_pkg::DATA_W-1:0] nx_pwdata;
        ipt_pkg::t_pick_in          nx_pixel;
        nx_start   = 1'b0;
        nx_psel    = 1'b0;
        nx_penable = 1'b0;
        nx_pwrite  = 1'b0;
        nx_paddr   = paddr;
        nx_pwdata  = pwdata;
        nx_pixel   = i_pixel;
        if (i_rst_n) begin
            if (pick_accepted) drive_q.delete(0);
            case (apb_st)
                APB_SETUP: begin
                    nx_psel    = 1'b1;
                    nx_penable = 1'b1;
                    nx_pwrite  = 1'b1;
                    apb_st     = APB_ACCESS;
                end
                APB_ACCESS: begin
                    apb_st = APB_IDLE;
                end
                default: begin
                    if (drive_q.size() != 0) begin
                        case (drive_q[0].kind)
                            CMD_PICK: begin
                                if ((start && !pick_accepted) ||
                                    $urandom_range(0, 99) >= drive_q[0].gap_pct) begin
                                    nx_start = 1'b1;
                                    nx_pixel = drive_q[0].pixel;
                                end
                            end
                            CMD_WRITE: begin
                                nx_psel   = 1'b1;
                                nx_pwrite = 1'b1;
                                nx_paddr  = {drive_q[0].reg_idx, 2'b00};
                                nx_pwdata = drive_q[0].wdata;
                                cfg_apply(drive_q[0].reg_idx, drive_q[0].wdata);
                                drive_q.delete(0);
                                apb_st = APB_SETUP;
                            end
                            default: begin
                                if (tile_q.size() == 0) begin
                                    if (settle_cnt >= SETTLE_CYCLES) begin
                                        settle_cnt = 0;
                                        drive_q.delete(0);
                                    end else begin
                                        settle_cnt++;
                                    end
                                end
                            end
                        endcase
                    end
                end
            endcase
        end
        start   <= nx_start;
        i_pixel <= nx_pixel;
        psel    <= nx_psel;
        penable <= nx_penable;
        pwrite  <= nx_pwrite;
        paddr   <= nx_paddr;
        pwdata  <= nx_pwdata;
    end

    // monitor: sample on the rising edge
    always @(posedge i_clk) begin : mon
        ipt_pkg::t_pick_out want;
        pick_accepted = i_rst_n && start && !busy;
        if (pick_accepted) tile_q.push_back(pick_tile(i_pixel, cfg_shadow));
        if (i_rst_n && o_done) begin
            if (tile_q.size() == 0) begin
                $error("result transaction with no pick outstanding");
                n_fail++;
            end else begin
                want = tile_q.pop_front();
                n_checked++;
                if (want.hit) n_hits++;
                if (o_result.hit !== want.hit) begin
                    $error("hit: expected %0b, got %0b", want.hit, o_result.hit);
                    n_fail++;
                end
                if (o_result.view_col !== want.view_col) begin
                    $error("view_col: expected %0d, got %0d", want.view_col, o_result.view_col);
                    n_fail++;
                end
                if (o_result.view_row !== want.view_row) begin
                    $error("view_row: expected %0d, got %0d", want.view_row, o_result.view_row);
                    n_fail++;
                end
            end
        end
    end

    task automatic push_pick(int x, int y, int gap);
        t_drive_cmd c;
        c.kind    = CMD_PICK;
        c.pixel   = '{screen_x: 12'(x), screen_y: 12'(y)};
        c.gap_pct = gap;
        c.reg_idx = ipt_pkg::REG_VIEWPORT_LEFT;
        c.wdata   = '0;
        drive_q.push_back(c);
    endtask

    task automatic push_settle();
        t_drive_cmd c;
        c.kind    = CMD_SETTLE;
        c.pixel   = '0;
        c.gap_pct = 0;
        c.reg_idx = ipt_pkg::REG_VIEWPORT_LEFT;
        c.wdata   = '0;
        drive_q.push_back(c);
    endtask

    task automatic push_write(ipt_pkg::t_reg_idx idx, int v, logic [31:0] mask);
        t_drive_cmd c;
        c.kind    = CMD_WRITE;
        c.pixel   = '0;
        c.gap_pct = 0;
        c.reg_idx = idx;
        c.wdata   = 32'(v) & mask;
        drive_q.push_back(c);
    endtask

    task automatic push_cfg(int left, int w, int h, int zoom, int sbx, int sby, int cx, int cy);
        push_settle();
        push_write(ipt_pkg::REG_VIEWPORT_LEFT,   left, 32'hFFF);
        push_write(ipt_pkg::REG_VIEWPORT_WIDTH,  w,    32'h1FFF);
        push_write(ipt_pkg::REG_VIEWPORT_HEIGHT, h,    32'h1FFF);
        push_write(ipt_pkg::REG_ZOOM_PERCENT,    zoom, 32'h1FF);
        push_write(ipt_pkg::REG_CAM_SUBTILE_X,   sbx,  32'h3F);
        push_write(ipt_pkg::REG_CAM_SUBTILE_Y,   sby,  32'h1F);
        push_write(ipt_pkg::REG_CAM_TILE_X,      cx,   32'h7FF);
        push_write(ipt_pkg::REG_CAM_TILE_Y,      cy,   32'h7FF);
        n_settings++;
    endtask

    initial begin
        cfg_shadow = '{viewport_left: 12'd0, viewport_width: 13'd1024,
                       viewport_height: 13'd768, zoom_percent: 9'd100,
                       camera_subtile_x: 6'd0, camera_subtile_y: 5'd0,
                       camera_tile_x: 11'sd0, camera_tile_y: 11'sd0};
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin : stim
        int left, w, h, zoom, sbx, sby, cx, cy, gap, x_hi, y_hi, x, y;

        // viewport edges and each diamond quadrant
        push_cfg(0, 1024, 768, 100, 0, 0, 0, 0);
        push_pick(0, 0, 0);       push_pick(4095, 4095, 0);
        push_pick(0, 24, 0);      push_pick(1023, 791, 0);
        push_pick(1024, 24, 0);   push_pick(0, 23, 0);
        push_pick(0, 792, 0);     push_pick(15, 31, 0);
        push_pick(5, 36, 0);      push_pick(45, 30, 0);
        push_pick(55, 37, 0);     push_pick(35, 44, 0);
        push_pick(58, 40, 0);     push_pick(10, 40, 0);
        // zoom out below viewport origin: negative offsets
        push_cfg(2000, 2096, 4072, 50, 0, 0, -512, -512);
        push_pick(2000, 24, 0);   push_pick(2047, 30, 0);
        push_pick(3000, 2000, 0); push_pick(4095, 4095, 0);
        // oversized registers, tile wraps past 12 bits
        push_cfg(0, 8191, 8191, 511, 63, 31, 1023, 1023);
        push_pick(4095, 4095, 0); push_pick(0, 24, 0); push_pick(2048, 2048, 0);
        // zoom 0, one-pixel viewport
        push_cfg(4095, 1, 1, 0, 59, 29, 1023, -1024);
        push_pick(4095, 24, 0);   push_pick(4095, 25, 0);
        // empty viewport
        push_cfg(100, 0, 0, 400, 0, 0, 0, 0);
        push_pick(100, 24, 0);

        for (int ph = 0; ph < 12; ph++) begin
            gap = (ph < 4) ? 12 : (ph < 8) ? 47 : 0;
            case (ph % 4)
                0: begin
                    left = $urandom_range(0, 400);
                    w    = $urandom_range(600, 2048);
                    h    = $urandom_range(400, 2048);
                    zoom = $urandom_range(50, 400);
                    sbx  = $urandom_range(0, 59);
                    sby  = $urandom_range(0, 29);
                    cx   = int'($urandom_range(0, 120)) - 40;
                    cy   = 2 * int'($urandom_range(0, 150)) - 60;
                end
                1: begin
                    left = $urandom_range(0, 1) ? 4095 : 0;
                    w    = $urandom_range(0, 1) ? 4096 : 1;
                    h    = $urandom_range(0, 1) ? 4096 : 1;
                    zoom = $urandom_range(0, 1) ? 400 : 50;
                    sbx  = $urandom_range(0, 1) ? 59 : 0;
                    sby  = $urandom_range(0, 1) ? 29 : 0;
                    cx   = $urandom_range(0, 1) ? 1023 : -512;
                    cy   = $urandom_range(0, 1) ? 1022 : -512;
                end
                2: begin
                    left = $urandom_range(0, 4095);
                    w    = $urandom_range(1, 4096);
                    h    = $urandom_range(1, 4096);
                    zoom = $urandom_range(50, 400);
                    sbx  = $urandom_range(0, 59);
                    sby  = $urandom_range(0, 29);
                    cx   = int'($urandom_range(0, 1535)) - 512;
                    cy   = 2 * int'($urandom_range(0, 767)) - 512;
                end
                default: begin
                    left = $urandom_range(0, 4095);
                    w    = $urandom_range(0, 8191);
                    h    = $urandom_range(0, 8191);
                    zoom = $urandom_range(0, 511);
                    sbx  = $urandom_range(0, 63);
                    sby  = $urandom_range(0, 31);
                    cx   = int'($urandom_range(0, 2047)) - 1024;
                    cy   = int'($urandom_range(0, 2047)) - 1024;
                end
            endcase
            push_cfg(left, w, h, zoom, sbx, sby, cx, cy);
            x_hi = (left + w - 1 > 4095) ? 4095 : left + w - 1;
            y_hi = (TOP + h - 1 > 4095) ? 4095 : TOP + h - 1;
            for (int i = 0; i < PHASE_PICKS; i++) begin
                if (w > 0 && h > 0 && $urandom_range(0, 99) < 85) begin
                    x = $urandom_range(left, x_hi);
                    y = $urandom_range(TOP, y_hi);
                end else begin
                    x = $urandom_range(0, 4095);
                    y = $urandom_range(0, 4095);
                end
                push_pick(x, y, gap);
                if (ph == 5 && i == PHASE_PICKS / 2) push_settle();
            end
        end

        while (drive_q.size() != 0 || apb_st != APB_IDLE) @(posedge i_clk);
        for (int g = 0; g < 1000 && tile_q.size() != 0; g++) @(posedge i_clk);
        repeat (2 * SETTLE_CYCLES) @(posedge i_clk);
        if (tile_q.size() != 0) begin
            $error("%0d picks never returned a result", tile_q.size());
            n_fail += tile_q.size();
        end
        $display("%0d picks checked (%0d in view) across %0d register settings",
                 n_checked, n_hits, n_settings);
        $display("settings included negative offsets, oversized registers and 12-bit wrap");
        if (n_fail == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
